>>> sv/tcw_pkg.sv
`default_nettype none

package tcw_pkg;

  // fixed field widths of the console beats
  localparam int COL_W = 7;
  localparam int ROW_W = 5;
  localparam int POS_W = 11;
  localparam int CHAR_W = 8;
  localparam int CELL_W = 16;

  localparam logic [CHAR_W-1:0] NL_CODE = 8'h0A;
  localparam logic [CHAR_W-1:0] NUL_CODE = 8'h00;
  localparam logic [CHAR_W-1:0] SPACE_CODE = 8'h20;
  localparam logic [7:0] RESET_COLOR = 8'h0F;
  localparam logic [CELL_W-1:0] RESET_CELL = {RESET_COLOR, SPACE_CODE};

  // configuration register indexes
  localparam logic REG_TEXT_COLOR = 1'b0;
  localparam logic REG_CURSOR_EN = 1'b1;

  typedef enum logic [2:0] {
    OP_STREAM = 3'd0,
    OP_PUT_AT = 3'd1,
    OP_SET_CURSOR = 3'd2,
    OP_CLEAR = 3'd3,
    OP_READ = 3'd4,
    OP_REPORT = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_COPY,
    S_BLANK,
    S_CLEAR,
    S_LATE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic init_fill;
    logic copy;
    logic blank;
    logic late;
    logic emit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic go_scroll;
    logic go_clear;
    logic copy_last;
    logic fill_last;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> sv/tcw_ctrl.sv
`default_nettype none

module tcw_ctrl import tcw_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd,
  output logic          busy
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT: begin
        if (stat.fill_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_next = S_EXEC;
      end
      S_EXEC: begin
        priority if (stat.go_clear) state_next = S_CLEAR;
        else if (stat.go_scroll) state_next = S_COPY;
        else state_next = S_IDLE;
      end
      S_COPY: begin
        if (stat.copy_last) state_next = S_BLANK;
      end
      S_BLANK: begin
        if (stat.fill_last) state_next = S_LATE;
      end
      S_CLEAR: begin
        if (stat.fill_last) state_next = S_LATE;
      end
      S_LATE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = 1'b1;
    unique case (state)
      S_INIT: cmd.init_fill = 1'b1;
      S_IDLE: begin
        busy = 1'b0;
        cmd.capture = start;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        cmd.emit = !stat.go_clear && !stat.go_scroll;
      end
      S_COPY: cmd.copy = 1'b1;
      S_BLANK: cmd.blank = 1'b1;
      S_CLEAR: cmd.blank = 1'b1;
      S_LATE: begin
        cmd.late = 1'b1;
        cmd.emit = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> sv/tcw_datapath.sv
`default_nettype none

module tcw_datapath import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS = 25
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire dp_cmd_t                   cmd,
  output dp_stat_t                       stat,
  input  wire logic [2:0]                operation,
  input  wire logic [CHAR_W-1:0]         char_code,
  input  wire logic signed [7:0]         col,
  input  wire logic signed [7:0]         row,
  input  wire logic                      cfg_we,
  input  wire logic                      cfg_index,
  input  wire logic [7:0]                cfg_data,
  output logic                           done,
  output logic                           cursor_report,
  output logic [POS_W-1:0]               cursor_pos,
  output logic [COL_W-1:0]               cursor_col,
  output logic [ROW_W-1:0]               cursor_row,
  output logic [CELL_W-1:0]              cell_word
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW = $clog2(CELLS);
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0] COPY_END = AW'(CELLS - COLUMNS);
  localparam logic [AW-1:0] PUT_ADDR = AW'((ROWS - 1) * COLUMNS);
  localparam logic [AW-1:0] ROW_STRIDE = AW'(COLUMNS);
  localparam logic [COL_W-1:0] COLS_C = COL_W'(COLUMNS);
  localparam logic [ROW_W:0] ROWS_C = (ROW_W + 1)'(ROWS);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
  localparam logic signed [7:0] COLS_S = 8'(COLUMNS);
  localparam logic signed [7:0] ROWS_S = 8'(ROWS);

  function automatic logic [COL_W-1:0] clamp_col(input logic signed [7:0] v);
    logic [COL_W-1:0] r;
    priority if (v < 0) r = '0;
    else if (v >= COLS_S) r = COLS_C - COL_W'(1);
    else r = v[COL_W-1:0];
    return r;
  endfunction

  function automatic logic [ROW_W-1:0] clamp_row(input logic signed [7:0] v);
    logic [ROW_W-1:0] r;
    priority if (v < 0) r = '0;
    else if (v >= ROWS_S) r = LAST_ROW;
    else r = v[ROW_W-1:0];
    return r;
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic [COL_W-1:0] x,
                                               input logic [ROW_W-1:0] y);
    return AW'(y) * ROW_STRIDE + AW'(x);
  endfunction

  // captured beat
  op_t                   op_q;
  logic [CHAR_W-1:0]     ch_q;
  logic signed [7:0]     col_q;
  logic signed [7:0]     row_q;

  logic [COL_W-1:0]      cur_col;
  logic [ROW_W-1:0]      cur_row;
  logic [7:0]            text_color;
  logic                  cursor_en;
  logic [AW-1:0]         idx;
  logic                  pend;
  logic                  rep_q;

  logic [CELL_W-1:0]     mem [CELLS];
  logic [CELL_W-1:0]     rdata;

  logic [COL_W-1:0]      col_next;
  logic [ROW_W-1:0]      row_next;
  logic                  rep_now;
  logic                  scroll_now;
  logic                  pend_next;
  logic                  we_exec;
  logic [AW-1:0]         wa_exec;
  logic [CELL_W-1:0]     wd_exec;
  logic [ROW_W:0]        row_inc;
  logic [ROW_W:0]        row_w;
  logic [COL_W-1:0]      col_w;
  logic                  wrap;

  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [CELL_W-1:0]     wr_data;
  logic [AW-1:0]         rd_addr;

  logic [COL_W-1:0]      sel_col;
  logic [ROW_W-1:0]      sel_row;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q <= op_t'(operation);
      ch_q <= char_code;
      col_q <= col;
      row_q <= row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= RESET_COLOR;
      cursor_en <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TEXT_COLOR: text_color <= cfg_data;
        REG_CURSOR_EN: cursor_en <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // per-operation decode, valid while exec is issued
  always_comb begin
    row_inc = {1'b0, cur_row} + (ROW_W + 1)'(1);
    wrap = cur_col >= COLS_C;
    col_w = wrap ? '0 : cur_col;
    row_w = wrap ? row_inc : {1'b0, cur_row};
    col_next = cur_col;
    row_next = cur_row;
    rep_now = 1'b0;
    scroll_now = 1'b0;
    pend_next = 1'b0;
    we_exec = 1'b0;
    wa_exec = cell_addr(clamp_col(col_q), clamp_row(row_q));
    wd_exec = {text_color, ch_q};
    unique case (op_q)
      OP_STREAM: begin
        priority if (ch_q == NL_CODE) begin
          rep_now = cursor_en;
          col_next = '0;
          if (row_inc >= ROWS_C) begin
            scroll_now = 1'b1;
            row_next = LAST_ROW;
          end else begin
            row_next = row_inc[ROW_W-1:0];
          end
        end else if (ch_q != NUL_CODE) begin
          rep_now = cursor_en;
          if (row_w >= ROWS_C) begin
            scroll_now = 1'b1;
            pend_next = 1'b1;
            col_next = COL_W'(1);
            row_next = LAST_ROW;
          end else begin
            we_exec = 1'b1;
            wa_exec = cell_addr(col_w, row_w[ROW_W-1:0]);
            col_next = col_w + COL_W'(1);
            row_next = row_w[ROW_W-1:0];
          end
        end else begin
          rep_now = 1'b0;
        end
      end
      OP_PUT_AT: begin
        we_exec = 1'b1;
        wd_exec = {text_color, (ch_q == NUL_CODE) ? SPACE_CODE : ch_q};
        rep_now = cursor_en;
      end
      OP_SET_CURSOR: begin
        if (col_q >= 0 && col_q < COLS_S && row_q >= 0 && row_q < ROWS_S) begin
          col_next = col_q[COL_W-1:0];
          row_next = row_q[ROW_W-1:0];
        end
        rep_now = cursor_en;
      end
      OP_CLEAR: begin
        col_next = '0;
        row_next = '0;
      end
      OP_READ: ;
      OP_REPORT: rep_now = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    stat.go_scroll = scroll_now;
    stat.go_clear = op_q == OP_CLEAR;
    stat.copy_last = idx == COPY_END;
    stat.fill_last = idx == LAST_CELL;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col <= '0;
      cur_row <= '0;
      pend <= 1'b0;
      rep_q <= 1'b0;
    end else if (cmd.exec) begin
      cur_col <= col_next;
      cur_row <= row_next;
      pend <= pend_next;
      rep_q <= rep_now;
    end
  end

  // sweep counter for the reset fill, scroll and clear passes
  always_ff @(posedge clk) begin
    if (rst || cmd.capture) begin
      idx <= '0;
    end else if (cmd.init_fill || cmd.blank || (cmd.copy && idx != COPY_END)) begin
      idx <= idx + AW'(1);
    end
  end

  always_comb begin
    wr_en = 1'b0;
    wr_addr = idx;
    wr_data = rdata;
    priority if (cmd.init_fill) begin
      wr_en = 1'b1;
      wr_data = RESET_CELL;
    end else if (cmd.copy) begin
      // data read in the cycle before, from one row below
      wr_en = idx != '0;
      wr_addr = idx - AW'(1);
    end else if (cmd.blank) begin
      wr_en = 1'b1;
      wr_data = {text_color, SPACE_CODE};
    end else if (cmd.late) begin
      wr_en = pend;
      wr_addr = PUT_ADDR;
      wr_data = {text_color, ch_q};
    end else if (cmd.exec) begin
      wr_en = we_exec;
      wr_addr = wa_exec;
      wr_data = wd_exec;
    end else begin
      wr_en = 1'b0;
    end
  end

  // read cell address comes straight from the ports so the data is ready in exec
  always_comb begin
    if (cmd.copy && idx != COPY_END) begin
      rd_addr = idx + ROW_STRIDE;
    end else begin
      rd_addr = cell_addr(clamp_col(col), clamp_row(row));
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  always_comb begin
    sel_col = cmd.late ? cur_col : col_next;
    sel_row = cmd.late ? cur_row : row_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      cursor_report <= cmd.late ? rep_q : rep_now;
      cursor_col <= sel_col;
      cursor_row <= sel_row;
      cursor_pos <= POS_W'(32'(sel_row) * COLUMNS + 32'(sel_col));
      cell_word <= (cmd.exec && op_q == OP_READ) ? rdata : '0;
    end
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.init_fill, cmd.copy, cmd.blank, cmd.late, cmd.exec, cmd.capture}))
    else $error("more than one datapath command at once");

  a_strobe_gap: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe on two cycles in a row");

  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    {1'b0, cur_row} < ROWS_C)
    else $error("cursor row past last row");

  a_col_bound: assert property (@(posedge clk) disable iff (rst)
    cur_col <= COLS_C)
    else $error("cursor column past screen width");

  a_late_after_pass: assert property (@(posedge clk) disable iff (rst)
    cmd.late |-> $past(cmd.blank))
    else $error("late step without a preceding blank pass");

endmodule

`default_nettype wire

>>> sv/text_console_cell_writer.sv
// result: put, set, read and report beats raise the result strobe from a register that
//   the exec step sets; scroll and clear run their screen passes before the late step sets it
// beats: a new beat is taken only in idle, after the exec step of the last one, which reads the
//   registered read port of the screen memory; scroll and clear hold busy for a full screen pass
// reset: after rst the screen memory is swept to space/color 0x0F, one cell a cycle,
//   with busy high for the whole sweep; the receiver cannot stall the result strobe
`default_nettype none

module text_console_cell_writer import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS = 25
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // command beat
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [2:0]           operation,
  input  wire logic [CHAR_W-1:0]    char_code,
  input  wire logic signed [7:0]    col,
  input  wire logic signed [7:0]    row,
  // register writes: index 0 text color, index 1 cursor enable
  input  wire logic                 cfg_we,
  input  wire logic                 cfg_index,
  input  wire logic [7:0]           cfg_data,
  // result beat, valid for the single cycle that done is high
  output logic                      done,
  output logic                      cursor_report,
  output logic [POS_W-1:0]          cursor_pos,
  output logic [COL_W-1:0]          cursor_col,
  output logic [ROW_W-1:0]          cursor_row,
  output logic [CELL_W-1:0]         cell_word
);

  // command and status between the sequencer and the screen datapath
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: reset sweep, idle, exec, scroll copy/blank, clear, late put
  tcw_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // screen memory, cursor, color registers and result registers
  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .operation     (operation),
    .char_code     (char_code),
    .col           (col),
    .row           (row),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .done          (done),
    .cursor_report (cursor_report),
    .cursor_pos    (cursor_pos),
    .cursor_col    (cursor_col),
    .cursor_row    (cursor_row),
    .cell_word     (cell_word)
  );

endmodule

`default_nettype wire

>>> verif/console_checker.sv
module console_checker import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS = 25
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    busy,
  input  logic [2:0]              operation,
  input  logic [CHAR_W-1:0]       char_code,
  input  logic signed [7:0]       col,
  input  logic signed [7:0]       row,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [7:0]              cfg_data,
  input  logic                    done,
  input  logic                    cursor_report,
  input  logic [POS_W-1:0]        cursor_pos,
  input  logic [COL_W-1:0]        cursor_col,
  input  logic [ROW_W-1:0]        cursor_row,
  input  logic [CELL_W-1:0]       cell_word,
  output int                      outstanding,
  output int                      fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CELLS = COLUMNS * ROWS;

  typedef struct packed {
    logic              report;
    logic [POS_W-1:0]  pos;
    logic [COL_W-1:0]  ccol;
    logic [ROW_W-1:0]  crow;
    logic [CELL_W-1:0] word;
  } cursor_beat_t;

  // shadow of the screen, cursor and registers
  logic [CELL_W-1:0] screen_img [CELLS];
  int                cur_x;
  int                cur_y;
  logic [7:0]        attr;
  logic              report_en;
  cursor_beat_t      expected_beats [$];

  function automatic int clamp_idx(int v, int n);
    if (v < 0) return 0;
    if (v >= n) return n - 1;
    return v;
  endfunction

  function automatic void fill_blank();
    int i;
    for (i = 0; i < CELLS; i++) screen_img[i] = {attr, SPACE_CODE};
  endfunction

  function automatic void scroll_screen();
    int i;
    for (i = 0; i < CELLS - COLUMNS; i++) screen_img[i] = screen_img[i + COLUMNS];
    for (i = CELLS - COLUMNS; i < CELLS; i++) screen_img[i] = {attr, SPACE_CODE};
    cur_x = 0;
    cur_y = ROWS - 1;
  endfunction

  // runs one command on the shadow and returns the beat it should produce
  function automatic cursor_beat_t apply_command(logic [2:0] op, logic [7:0] ch,
                                                 int c, int r);
    cursor_beat_t b;
    logic [7:0]   put_ch;
    int           x;
    int           y;
    b = '0;
    case (op)
      OP_STREAM: begin
        if (ch == NL_CODE) begin
          cur_x = 0;
          cur_y++;
          if (cur_y >= ROWS) scroll_screen();
          b.report = report_en;
        end else if (ch != NUL_CODE) begin
          if (cur_x >= COLUMNS) begin
            cur_x = 0;
            cur_y++;
          end
          if (cur_y >= ROWS) scroll_screen();
          screen_img[cur_y * COLUMNS + cur_x] = {attr, ch};
          cur_x++;
          b.report = report_en;
        end
      end
      OP_PUT_AT: begin
        put_ch = (ch == NUL_CODE) ? SPACE_CODE : ch;
        x = clamp_idx(c, COLUMNS);
        y = clamp_idx(r, ROWS);
        screen_img[y * COLUMNS + x] = {attr, put_ch};
        b.report = report_en;
      end
      OP_SET_CURSOR: begin
        if (c >= 0 && c < COLUMNS && r >= 0 && r < ROWS) begin
          cur_x = c;
          cur_y = r;
        end
        b.report = report_en;
      end
      OP_CLEAR: begin
        fill_blank();
        cur_x = 0;
        cur_y = 0;
      end
      OP_READ: begin
        x = clamp_idx(c, COLUMNS);
        y = clamp_idx(r, ROWS);
        b.word = screen_img[y * COLUMNS + x];
      end
      OP_REPORT: b.report = 1'b1;
      default: ;
    endcase
    b.pos = POS_W'(cur_y * COLUMNS + cur_x);
    b.ccol = COL_W'(cur_x);
    b.crow = ROW_W'(cur_y);
    return b;
  endfunction

  always @(posedge clk) begin
    cursor_beat_t got;
    cursor_beat_t want;
    if (rst) begin
      attr = RESET_COLOR;
      report_en = 1'b1;
      fill_blank();
      cur_x = 0;
      cur_y = 0;
      expected_beats.delete();
      fail_count = 0;
    end else begin
      if (done) begin
        got = {cursor_report, cursor_pos, cursor_col, cursor_row, cell_word};
        if (expected_beats.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result beat with nothing pending: %s%0d pos=%0d col=%0d row=%0d %s%h",
                     $realtime, "report=", got.report, got.pos, got.ccol, got.crow,
                     "cell=", got.word);
        end else begin
          want = expected_beats.pop_front();
          if (got.report !== want.report || got.pos !== want.pos || got.ccol !== want.ccol ||
              got.crow !== want.crow || got.word !== want.word) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: result mismatch", $realtime);
              $display("  expected report=%0d pos=%0d col=%0d row=%0d cell=%h",
                       want.report, want.pos, want.ccol, want.crow, want.word);
              $display("  actual   report=%0d pos=%0d col=%0d row=%0d cell=%h",
                       got.report, got.pos, got.ccol, got.crow, got.word);
            end
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_TEXT_COLOR: attr = cfg_data;
          REG_CURSOR_EN:  report_en = cfg_data[0];
          default: ;
        endcase
      end
      if (start && !busy)
        expected_beats.push_back(apply_command(operation, char_code, col, row));
    end
    outstanding <= expected_beats.size();
  end

endmodule

>>> verif/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tcw_pkg::*;

  localparam int COLUMNS = 80;
  localparam int ROWS = 25;
  // codes the block decodes as no-ops
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  // random beats per register setting, six settings in all
  localparam int PHASE_BEATS = 64;
  localparam int NUM_PHASES = 6;
  // quiet cycles after the last result before the verdict
  localparam int DRAIN_CYCLES = 32;
  // worst case is every beat scrolling (one screen pass each), taken about four times over
  localparam longint LIMIT_CYCLES = 4_000_000;

  // everything driven to a known value from time zero
  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic [2:0]          operation = OP_STREAM;
  logic [CHAR_W-1:0]   char_code = NUL_CODE;
  logic signed [7:0]   col = '0;
  logic signed [7:0]   row = '0;
  logic                cfg_we = 1'b0;
  logic                cfg_index = REG_TEXT_COLOR;
  logic [7:0]          cfg_data = '0;

  logic                busy;
  logic                done;
  logic                cursor_report;
  logic [POS_W-1:0]    cursor_pos;
  logic [COL_W-1:0]    cursor_col;
  logic [ROW_W-1:0]    cursor_row;
  logic [CELL_W-1:0]   cell_word;

  int                  outstanding;
  int                  fail_count;
  int                  beats_sent = 0;
  // when set the command side never idles
  bit                  steady = 1'b0;
  longint              cycle_count = 0;

  always #4 clk = ~clk;

  text_console_cell_writer #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .operation(operation),
    .char_code(char_code),
    .col(col),
    .row(row),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .done(done),
    .cursor_report(cursor_report),
    .cursor_pos(cursor_pos),
    .cursor_col(cursor_col),
    .cursor_row(cursor_row),
    .cell_word(cell_word)
  );

  // predicts and compares every result beat
  console_checker #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS)
  ) i_checker (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .operation(operation),
    .char_code(char_code),
    .col(col),
    .row(row),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .done(done),
    .cursor_report(cursor_report),
    .cursor_pos(cursor_pos),
    .cursor_col(cursor_col),
    .cursor_row(cursor_row),
    .cell_word(cell_word),
    .outstanding(outstanding),
    .fail_count(fail_count)
  );

  // one command beat: random idle first unless steady, then hold start until busy is low at an edge
  task automatic issue_command(logic [2:0] op, logic [7:0] ch, logic [7:0] c, logic [7:0] r);
    if (!steady) begin
      while ($urandom_range(99) < 35) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start <= 1'b1;
    operation <= op;
    char_code <= ch;
    col <= c;
    row <= r;
    @(posedge clk);
    // busy read here is the value the edge just sampled
    while (busy) @(posedge clk);
    // spare codes and stream nul change nothing in the block, so they don't count
    if (!(op == OP_SPARE_LO || op == OP_SPARE_HI || (op == OP_STREAM && ch == NUL_CODE)))
      beats_sent++;
  endtask

  // drop start and wait until every predicted beat is back and the block is idle
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0 || busy);
  endtask

  // new register setting, only written while nothing is in flight
  task automatic configure(logic [7:0] color, logic cursor_on);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= REG_TEXT_COLOR;
    cfg_data <= color;
    @(posedge clk);
    cfg_index <= REG_CURSOR_EN;
    cfg_data <= {7'b0, cursor_on};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // half the time anywhere in the signed range (clamps, refusals), else on screen
  function automatic logic [7:0] pick_coord(int span);
    if ($urandom_range(1)) return 8'($urandom_range(255));
    return 8'($urandom_range(span - 1));
  endfunction

  // text with a fair share of newlines and nul bytes
  function automatic logic [7:0] pick_char();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return NL_CODE;
    if (roll < 15) return NUL_CODE;
    return 8'($urandom_range(255));
  endfunction

  // one random scene, mostly text runs that reach line wrap and scroll
  task automatic random_scene();
    int          roll;
    int          n;
    int          i;
    logic [7:0]  px;
    logic [7:0]  py;
    roll = $urandom_range(99);
    if (roll < 35) begin
      // park the cursor near the bottom right corner half the time
      if ($urandom_range(1))
        issue_command(OP_SET_CURSOR, 8'($urandom_range(255)),
                      8'($urandom_range(COLUMNS - 6, COLUMNS - 1)),
                      8'($urandom_range(ROWS - 3, ROWS - 1)));
      n = $urandom_range(3, 24);
      for (i = 0; i < n; i++) issue_command(OP_STREAM, pick_char(), pick_coord(COLUMNS),
                                            pick_coord(ROWS));
      // look at the bottom rows to catch a bad scroll
      if ($urandom_range(1))
        issue_command(OP_READ, 8'($urandom_range(255)), 8'($urandom_range(COLUMNS - 1)),
                      8'($urandom_range(ROWS - 3, ROWS - 1)));
    end else if (roll < 58) begin
      px = pick_coord(COLUMNS);
      py = pick_coord(ROWS);
      issue_command(OP_PUT_AT, 8'($urandom_range(255)), px, py);
      if ($urandom_range(3) != 0) issue_command(OP_READ, 8'($urandom_range(255)), px, py);
    end else if (roll < 72) begin
      issue_command(OP_READ, 8'($urandom_range(255)), pick_coord(COLUMNS), pick_coord(ROWS));
    end else if (roll < 84) begin
      issue_command(OP_SET_CURSOR, 8'($urandom_range(255)), pick_coord(COLUMNS),
                    pick_coord(ROWS));
    end else if (roll < 90) begin
      issue_command(OP_REPORT, 8'($urandom_range(255)), 8'($urandom_range(255)),
                    8'($urandom_range(255)));
    end else if (roll < 93) begin
      issue_command($urandom_range(1) ? OP_SPARE_HI : OP_SPARE_LO, 8'($urandom_range(255)),
                    8'($urandom_range(255)), 8'($urandom_range(255)));
    end else if (roll < 96) begin
      // each clear costs a full screen pass, keep them rare
      issue_command(OP_CLEAR, 8'($urandom_range(255)), 8'($urandom_range(255)),
                    8'($urandom_range(255)));
    end else begin
      issue_command(OP_STREAM, 8'($urandom_range(255)), 8'($urandom_range(255)),
                    8'($urandom_range(255)));
    end
  endtask

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int p;
    int target;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed part, at reset register values (color 0x0f, cursor reports on)
    issue_command(OP_READ, NUL_CODE, 0, 0);                 // reset cell
    issue_command(OP_READ, NUL_CODE, -128, -128);           // clamp low
    issue_command(OP_PUT_AT, 8'h41, -128, -128);            // put clamps to top left
    issue_command(OP_PUT_AT, NUL_CODE, 127, 127);           // nul written as space, bottom right
    issue_command(OP_PUT_AT, 8'hFF, 8'(COLUMNS - 1), 0);
    issue_command(OP_READ, NUL_CODE, 127, 127);
    issue_command(OP_READ, NUL_CODE, 0, 0);
    issue_command(OP_READ, NUL_CODE, 8'(COLUMNS - 1), 0);
    issue_command(OP_SET_CURSOR, NUL_CODE, 8'(COLUMNS), 0); // refused, column off screen
    issue_command(OP_SET_CURSOR, NUL_CODE, -1, 5);          // refused, negative column
    issue_command(OP_SET_CURSOR, NUL_CODE, 0, 8'(ROWS));    // refused, row off screen
    issue_command(OP_SET_CURSOR, NUL_CODE, 8'(COLUMNS - 1), 8'(ROWS - 1));
    issue_command(OP_STREAM, 8'hFF, 0, 0);                  // cursor column reaches the width
    issue_command(OP_REPORT, NUL_CODE, 0, 0);
    issue_command(OP_STREAM, 8'h78, 0, 0);                  // wrap past last column, scroll
    issue_command(OP_READ, NUL_CODE, 8'(COLUMNS - 1), 8'(ROWS - 2)); // moved up one line
    issue_command(OP_STREAM, NUL_CODE, 0, 0);               // nul does nothing
    issue_command(OP_STREAM, NL_CODE, 0, 0);                // newline on last row scrolls
    issue_command(OP_READ, NUL_CODE, 0, 8'(ROWS - 2));
    issue_command(OP_SPARE_LO, 8'hFF, -1, -1);
    issue_command(OP_SPARE_HI, 8'hFF, 127, 127);
    issue_command(OP_SET_CURSOR, NUL_CODE, 5, 3);
    issue_command(OP_STREAM, NL_CODE, 0, 0);                // newline mid screen
    issue_command(OP_CLEAR, NUL_CODE, 0, 0);
    issue_command(OP_READ, NUL_CODE, 0, 8'(ROWS - 2));

    // random part, one register setting per phase, extremes included
    for (p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: configure(8'h00, 1'b0);
        1: configure(8'hFF, 1'b1);
        2: configure(8'($urandom_range(255)), 1'b0);
        3: configure(8'($urandom_range(255)), 1'b1);
        4: configure(8'hFF, 1'b0);
        default: configure(8'($urandom_range(255)), 1'b1);
      endcase
      // one whole phase without command-side idling
      steady = (p == 3);
      target = beats_sent + PHASE_BEATS;
      while (beats_sent < target) random_scene();
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> sim.f
sv/tcw_pkg.sv
sv/tcw_ctrl.sv
sv/tcw_datapath.sv
sv/text_console_cell_writer.sv
verif/console_checker.sv
verif/tb_top.sv
